// ===== src/spd_pkg.sv =====
// Shared types and codes for the slotted page directory.
// Used by every module of the block; depends on nothing.
package spd_pkg;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_GET     = 3'd3,
    MODE_UPDATE  = 3'd4,
    MODE_COMPACT = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_LEN    = 3'd1,
    STAT_NO_SPACE   = 3'd2,
    STAT_BAD_SLOT   = 3'd3,
    STAT_DELETED    = 3'd4,
    STAT_TABLE_FULL = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TOMB,
    S_SUM,
    S_MOVE,
    S_RESP
  } state_e;

  // One slot directory entry.
  typedef struct packed {
    logic        del;
    logic [12:0] len;
    logic [12:0] off;
  } slot_ent_t;

  // Access request to the slot memory.
  typedef struct packed {
    logic      we;
    logic [5:0] waddr;
    slot_ent_t wdata;
    logic [5:0] raddr;
  } mem_req_t;

  // Pending single result.
  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic [12:0] off;
    logic [12:0] len;
    logic [12:0] pad;
  } res_t;

  // Full result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  result_slot;
    logic [12:0] record_offset;
    logic [12:0] record_length;
    logic [12:0] pad_length;
    logic [12:0] move_source;
    logic        is_move;
    logic [12:0] free_bytes;
    logic [6:0]  live_records;
    logic        last;
  } out_t;

endpackage

// ===== src/spd_in_if.sv =====
// Request channel of the slotted page directory.
// Standalone; carries valid, ready and the request fields.
interface spd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [5:0]  slot_id;
  logic [12:0] length;
  logic [31:0] page_id;

  modport source (output valid, mode, slot_id, length, page_id, input ready);
  modport sink (input valid, mode, slot_id, length, page_id, output ready);
endinterface

// ===== src/spd_out_if.sv =====
// Result channel of the slotted page directory.
// Standalone; carries valid, ready and the result fields.
interface spd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  result_slot;
  logic [12:0] record_offset;
  logic [12:0] record_length;
  logic [12:0] pad_length;
  logic [12:0] move_source;
  logic        is_move;
  logic [12:0] free_bytes;
  logic [6:0]  live_records;
  logic        last;

  modport source (output valid, status, result_slot, record_offset, record_length,
                  pad_length, move_source, is_move, free_bytes, live_records, last,
                  input ready);
  modport sink (input valid, status, result_slot, record_offset, record_length,
                pad_length, move_source, is_move, free_bytes, live_records, last,
                output ready);
endinterface

// ===== src/slotted_page_directory.sv =====
// Slotted page directory: top level with the sequencing controller.
// Depends on spd_pkg, spd_in_if, spd_out_if, spd_slot_ram and spd_out_reg.
//
// Usage: a request on in_i (mode, slot_id, length, page_id) transfers when
// valid and ready are high; ready is high only while the block is idle, so one
// request is worked on at a time. Results leave on out_o through an output
// register; last marks the final result of a request. Compact gives one move
// command per live record, or a single result if there is none; other modes
// give a single result. Insert scans the slot table through the single memory
// read port; a growing update checks its slot before the scan and, when it
// moves the record, also marks its old slot as a tombstone. Compact makes two
// passes over the table.
// Records always sit at descending offsets with rising slot index, so compact
// walks the table once in index order to emit moves.
// Reset empties the page (no slots, data start at the page end); the slot
// memory itself is not cleared. If the receiver stalls, the controller holds
// the pending result, and compact pauses between moves; nothing is dropped.
module slotted_page_directory #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int SLOT_BYTES   = 8,
  parameter int SLOT_CAP     = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spd_in_if.sink    in_i,
  spd_out_if.source out_o
);

  localparam int LenMax = PAGE_BYTES - HEADER_BYTES - SLOT_BYTES;

  spd_pkg::state_e    state_q, state_d;
  spd_pkg::mem_req_t  mreq;
  spd_pkg::slot_ent_t rd;
  spd_pkg::slot_ent_t sent_q, sent_d;
  spd_pkg::res_t      res_q, res_d;
  spd_pkg::out_t      out_d;
  logic               out_load, out_free;

  logic [2:0]  mode_q, mode_d;
  logic [5:0]  sid_q, sid_d;
  logic [12:0] len_q, len_d;
  logic        upd_q, upd_d;
  logic [6:0]  idx_q, idx_d;
  logic        pv_q, pv_d;
  logic [5:0]  pidx_q, pidx_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [12:0] ds_q, ds_d;
  logic [6:0]  live_q, live_d;
  logic [31:0] pid_q, pid_d;
  logic [12:0] sum_q, sum_d;
  logic [6:0]  n_q, n_d;
  logic [5:0]  k_q, k_d;
  logic [12:0] pos_q, pos_d;
  logic [6:0]  ocnt_q, ocnt_d;

  logic [13:0] slot_end, need;
  logic [12:0] gap;
  logic        bad_len_in, bad_len_q;

  spd_slot_ram #(.Depth(SLOT_CAP)) u_ram (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(rd)
  );

  spd_out_reg u_out (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(out_load),
    .data_i(out_d),
    .free_o(out_free),
    .out_o (out_o)
  );

  assign in_i.ready = (state_q == spd_pkg::S_IDLE);

  // Free gap between the slot array end and the data start.
  assign slot_end = 14'(HEADER_BYTES) + 14'(cnt_q) * 14'(SLOT_BYTES);
  assign need     = slot_end + 14'(SLOT_BYTES) + {1'b0, len_q};
  assign gap      = ({1'b0, ds_q} > slot_end) ? 13'({1'b0, ds_q} - slot_end) : 13'd0;

  assign bad_len_in = (in_i.length == 13'd0) || (in_i.length > 13'(LenMax));
  assign bad_len_q  = (len_q == 13'd0) || (len_q > 13'(LenMax));

  // Next state, memory requests and results.
  always_comb begin
    state_d  = state_q;
    sent_d   = sent_q;
    res_d    = res_q;
    mode_d   = mode_q;
    sid_d    = sid_q;
    len_d    = len_q;
    upd_d    = upd_q;
    idx_d    = idx_q;
    pv_d     = pv_q;
    pidx_d   = pidx_q;
    cnt_d    = cnt_q;
    ds_d     = ds_q;
    live_d   = live_q;
    pid_d    = pid_q;
    sum_d    = sum_q;
    n_d      = n_q;
    k_d      = k_q;
    pos_d    = pos_q;
    ocnt_d   = ocnt_q;
    mreq     = '0;
    mreq.raddr = idx_q[5:0];
    out_load = 1'b0;
    out_d    = '0;

    unique case (state_q)
      spd_pkg::S_IDLE: begin
        mreq.raddr = in_i.slot_id;
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          sid_d   = in_i.slot_id;
          len_d   = in_i.length;
          upd_d   = 1'b0;
          idx_d   = '0;
          pv_d    = 1'b0;
          sum_d   = '0;
          n_d     = '0;
          res_d   = '0;
          res_d.status = spd_pkg::STAT_OK;
          state_d = spd_pkg::S_RESP;
          unique case (in_i.mode) inside
            spd_pkg::MODE_INIT: begin
              cnt_d  = '0;
              ds_d   = 13'(PAGE_BYTES);
              live_d = '0;
              pid_d  = in_i.page_id;
            end
            spd_pkg::MODE_INSERT: begin
              if (bad_len_in) begin
                res_d.status = spd_pkg::STAT_BAD_LEN;
              end else begin
                state_d = spd_pkg::S_SCAN;
              end
            end
            spd_pkg::MODE_REMOVE, spd_pkg::MODE_GET, spd_pkg::MODE_UPDATE: begin
              if ({1'b0, in_i.slot_id} >= cnt_q) begin
                res_d.status = spd_pkg::STAT_BAD_SLOT;
              end else begin
                state_d = spd_pkg::S_CHECK;
              end
            end
            spd_pkg::MODE_COMPACT: begin
              if (cnt_q != 7'd0) begin
                state_d = spd_pkg::S_SUM;
              end
            end
            default: ;
          endcase
        end
      end

      // Slot entry addressed by remove, get or update is on the read port.
      spd_pkg::S_CHECK: begin
        state_d = spd_pkg::S_RESP;
        if (rd.del) begin
          res_d.status = spd_pkg::STAT_DELETED;
        end else begin
          case (mode_q)
            spd_pkg::MODE_REMOVE: begin
              mreq.we    = 1'b1;
              mreq.waddr = sid_q;
              mreq.wdata = '{del: 1'b1, len: rd.len, off: rd.off};
              live_d     = live_q - 7'd1;
              res_d.slot = sid_q;
            end
            spd_pkg::MODE_GET: begin
              res_d.slot = sid_q;
              res_d.off  = rd.off;
              res_d.len  = rd.len;
            end
            default: begin
              if (len_q <= rd.len) begin
                res_d.slot = sid_q;
                res_d.off  = rd.off;
                res_d.len  = len_q;
                res_d.pad  = rd.len - len_q;
              end else if (bad_len_q) begin
                res_d.status = spd_pkg::STAT_BAD_LEN;
              end else begin
                sent_d  = rd;
                upd_d   = 1'b1;
                state_d = spd_pkg::S_SCAN;
              end
            end
          endcase
        end
      end

      // Look for the lowest reusable tombstone, then try to append.
      spd_pkg::S_SCAN: begin
        if (pv_q && rd.del && (rd.len >= len_q)) begin
          mreq.we    = 1'b1;
          mreq.waddr = pidx_q;
          mreq.wdata = '{del: 1'b0, len: len_q, off: rd.off};
          if (!upd_q) begin
            live_d = live_q + 7'd1;
          end
          res_d.slot = pidx_q;
          res_d.off  = rd.off;
          res_d.len  = len_q;
          state_d    = upd_q ? spd_pkg::S_TOMB : spd_pkg::S_RESP;
        end else if (!pv_q && (idx_q >= cnt_q)) begin
          state_d = spd_pkg::S_RESP;
          if (cnt_q == 7'(SLOT_CAP)) begin
            res_d.status = spd_pkg::STAT_TABLE_FULL;
          end else if ({1'b0, ds_q} < need) begin
            res_d.status = spd_pkg::STAT_NO_SPACE;
          end else begin
            mreq.we    = 1'b1;
            mreq.waddr = cnt_q[5:0];
            mreq.wdata = '{del: 1'b0, len: len_q, off: ds_q - len_q};
            ds_d       = ds_q - len_q;
            cnt_d      = cnt_q + 7'd1;
            if (!upd_q) begin
              live_d = live_q + 7'd1;
            end
            res_d.slot = cnt_q[5:0];
            res_d.off  = ds_q - len_q;
            res_d.len  = len_q;
            state_d    = upd_q ? spd_pkg::S_TOMB : spd_pkg::S_RESP;
          end
        end else begin
          pv_d   = idx_q < cnt_q;
          pidx_d = idx_q[5:0];
          if (idx_q < cnt_q) begin
            idx_d = idx_q + 7'd1;
          end
        end
      end

      // A growing update that moved leaves its old slot as a tombstone.
      spd_pkg::S_TOMB: begin
        mreq.we    = 1'b1;
        mreq.waddr = sid_q;
        mreq.wdata = '{del: 1'b1, len: sent_q.len, off: sent_q.off};
        state_d    = spd_pkg::S_RESP;
      end

      // First compact pass: count live records and their total length.
      spd_pkg::S_SUM: begin
        if (pv_q && !rd.del) begin
          sum_d = sum_q + rd.len;
          n_d   = n_q + 7'd1;
        end
        if (!pv_q && (idx_q >= cnt_q)) begin
          if (n_q == 7'd0) begin
            cnt_d   = '0;
            ds_d    = 13'(PAGE_BYTES);
            live_d  = '0;
            state_d = spd_pkg::S_RESP;
          end else begin
            ocnt_d  = cnt_q;
            cnt_d   = n_q;
            live_d  = n_q;
            ds_d    = 13'(PAGE_BYTES) - sum_q;
            idx_d   = '0;
            pv_d    = 1'b0;
            k_d     = '0;
            pos_d   = 13'(PAGE_BYTES);
            state_d = spd_pkg::S_MOVE;
          end
        end else begin
          pv_d   = idx_q < cnt_q;
          pidx_d = idx_q[5:0];
          if (idx_q < cnt_q) begin
            idx_d = idx_q + 7'd1;
          end
        end
      end

      // Second compact pass: pack live records and emit one move each.
      spd_pkg::S_MOVE: begin
        if (pv_q && !rd.del && !out_free) begin
          mreq.raddr = pidx_q;
        end else begin
          pv_d   = idx_q < ocnt_q;
          pidx_d = idx_q[5:0];
          if (idx_q < ocnt_q) begin
            idx_d = idx_q + 7'd1;
          end
          if (pv_q && !rd.del) begin
            mreq.we    = 1'b1;
            mreq.waddr = k_q;
            mreq.wdata = '{del: 1'b0, len: rd.len, off: pos_q - rd.len};
            pos_d      = pos_q - rd.len;
            k_d        = k_q + 6'd1;
            out_load            = 1'b1;
            out_d.status        = spd_pkg::STAT_OK;
            out_d.result_slot   = k_q;
            out_d.record_offset = pos_q - rd.len;
            out_d.record_length = rd.len;
            out_d.move_source   = rd.off;
            out_d.is_move       = 1'b1;
            out_d.free_bytes    = gap;
            out_d.live_records  = live_q;
            out_d.last          = ({1'b0, k_q} == (cnt_q - 7'd1));
            if (out_d.last) begin
              state_d = spd_pkg::S_IDLE;
            end
          end
        end
      end

      // Single result goes to the output register once it is free.
      spd_pkg::S_RESP: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.status        = res_q.status;
          out_d.result_slot   = res_q.slot;
          out_d.record_offset = res_q.off;
          out_d.record_length = res_q.len;
          out_d.pad_length    = res_q.pad;
          out_d.free_bytes    = gap;
          out_d.live_records  = live_q;
          out_d.last          = 1'b1;
          state_d             = spd_pkg::S_IDLE;
        end
      end

      default: state_d = spd_pkg::S_IDLE;
    endcase
  end

  // Control and page header registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spd_pkg::S_IDLE;
      cnt_q   <= '0;
      ds_q    <= 13'(PAGE_BYTES);
      live_q  <= '0;
      pid_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ds_q    <= ds_d;
      live_q  <= live_d;
      pid_q   <= pid_d;
      pv_q    <= pv_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    sent_q <= sent_d;
    res_q  <= res_d;
    mode_q <= mode_d;
    sid_q  <= sid_d;
    len_q  <= len_d;
    upd_q  <= upd_d;
    idx_q  <= idx_d;
    pidx_q <= pidx_d;
    sum_q  <= sum_d;
    n_q    <= n_d;
    k_q    <= k_d;
    pos_q  <= pos_d;
    ocnt_q <= ocnt_d;
  end

endmodule

// ===== src/spd_slot_ram.sv =====
// Slot directory memory: one write and one registered read per cycle.
// Depends on spd_pkg.
module spd_slot_ram #(
  parameter int Depth = 64
) (
  input  logic              clk_i,
  input  spd_pkg::mem_req_t req_i,
  output spd_pkg::slot_ent_t rdata_o
);

  spd_pkg::slot_ent_t mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== src/spd_out_reg.sv =====
// Output register of the result channel; frees the controller from the sink.
// Depends on spd_pkg and spd_out_if.
module spd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  spd_pkg::out_t data_i,
  output logic          free_o,
  spd_out_if.source     out_o
);

  logic          valid_q;
  spd_pkg::out_t data_q;

  assign free_o = !valid_q || out_o.ready;

  // Valid flag: set on load, cleared once the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.status        = data_q.status;
  assign out_o.result_slot   = data_q.result_slot;
  assign out_o.record_offset = data_q.record_offset;
  assign out_o.record_length = data_q.record_length;
  assign out_o.pad_length    = data_q.pad_length;
  assign out_o.move_source   = data_q.move_source;
  assign out_o.is_move       = data_q.is_move;
  assign out_o.free_bytes    = data_q.free_bytes;
  assign out_o.live_records  = data_q.live_records;
  assign out_o.last          = data_q.last;

endmodule
